### rtl/core/ugct_pkg.sv
// Shared types, function codes and helpers for the graph cycle tracker.
`default_nettype none

package ugct_pkg;

  // Fixed widths of the transaction fields
  localparam int VTX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int DEG_W   = 8;
  localparam int EDGE_W  = 16;

  localparam logic [CFG_W-1:0]  VCOUNT_RESET = 7'd64;
  localparam logic [DEG_W-1:0]  DEG_MAX      = 8'hFF;
  localparam logic [EDGE_W-1:0] EDGE_MAX     = 16'hFFFF;

  // Operation codes; the unused code behaves as a query
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic              edge_present;
    logic              cycle_found;
    logic [EDGE_W-1:0] edge_count;
    logic [DEG_W-1:0]  degree_a;
    logic              bad_vertex;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_B,
    S_DECIDE,
    S_SCAN,
    S_WRITE_A,
    S_WRITE_B,
    S_RESULT
  } state_t;

  // Saturating degree increment
  function automatic logic [DEG_W-1:0] deg_add(input logic [DEG_W-1:0] d,
                                               input logic [1:0] k);
    logic [DEG_W:0] s;
    s = {1'b0, d} + {{(DEG_W-1){1'b0}}, k};
    return s[DEG_W] ? DEG_MAX : s[DEG_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/undirected_graph_cycle_tracker.sv
// Graph cycle tracker: clear and rejected items go straight to the result state; a
// query reads both vertex entries, and an add also writes them back (one entry for a
// self-loop). An add that merges two components first runs a relabel sweep over every
// entry, checking one entry per cycle. One transaction is in work at a time; the
// next is taken in the cycle after the result is registered. Reset (synchronous)
// empties the graph through the per-entry valid bits and sets vertex_count to 64.
`default_nettype none

module undirected_graph_cycle_tracker #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ugct_pkg::in_item_t          in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ugct_pkg::out_item_t              out_item,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ugct_pkg::CFG_W-1:0]  cfg_data
);
  import ugct_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);

  state_t state, state_next;

  logic [CFG_W-1:0]        vertex_count;
  logic [CFG_W-1:0]        limit;
  logic                    in_bad;
  logic                    in_take;
  logic                    out_load;

  logic [1:0]              func_q;
  logic [VW-1:0]           a_q, b_q;
  logic [MAX_VERTICES-1:0] row_a, row_b;
  logic [VW-1:0]           label_a, label_b;
  logic [DEG_W-1:0]        deg_a, deg_b;
  logic                    merge_q;
  logic                    present_q;
  logic                    bad_q;
  logic [DEG_W-1:0]        deg_q;
  logic                    cycle_flag;
  logic [EDGE_W-1:0]       total_edges;
  logic [VW:0]             scan_idx;
  logic [VW-1:0]           pend_idx;
  logic                    new_edge;
  logic [DEG_W-1:0]        deg_a_new;

  // Store interface
  logic                    st_clear;
  logic [VW-1:0]           st_rd_addr;
  logic [MAX_VERTICES-1:0] st_rd_row;
  logic [VW-1:0]           st_rd_label;
  logic [DEG_W-1:0]        st_rd_degree;
  logic                    st_wr_en;
  logic [VW-1:0]           st_wr_addr;
  logic [MAX_VERTICES-1:0] st_wr_row;
  logic [VW-1:0]           st_wr_label;
  logic [DEG_W-1:0]        st_wr_degree;

  ugct_store #(.MAX_VERTICES(MAX_VERTICES)) u_store (
    .clk       (clk),
    .rst       (rst),
    .clear     (st_clear),
    .rd_addr   (st_rd_addr),
    .rd_row    (st_rd_row),
    .rd_label  (st_rd_label),
    .rd_degree (st_rd_degree),
    .wr_en     (st_wr_en),
    .wr_addr   (st_wr_addr),
    .wr_row    (st_wr_row),
    .wr_label  (st_wr_label),
    .wr_degree (st_wr_degree)
  );

  // Range check against min(vertex_count, MAX_VERTICES)
  assign limit  = (vertex_count < CFG_W'(MAX_VERTICES)) ? vertex_count
                                                        : CFG_W'(MAX_VERTICES);
  assign in_bad = ({1'b0, in_item.vertex_a} >= limit) ||
                  ({1'b0, in_item.vertex_b} >= limit);
  assign in_take  = in_valid && in_ready;
  assign out_load = (state == S_RESULT) && (!out_valid || out_ready);

  // Edge that can join components or close a cycle
  assign new_edge  = (a_q != b_q) && !row_a[b_q];
  assign deg_a_new = deg_add(deg_a, (a_q == b_q) ? 2'd2 : 2'd1);

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          if (in_item.func == FUNC_CLEAR || in_bad) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_READ_B;
          end
        end
      end
      S_READ_B: state_next = S_DECIDE;
      S_DECIDE: begin
        if (func_q != FUNC_ADD) begin
          state_next = S_RESULT;
        end else if (new_edge && (label_a != st_rd_label)) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_WRITE_A;
        end
      end
      S_SCAN: begin
        if (scan_idx == (VW+1)'(MAX_VERTICES)) begin
          state_next = S_WRITE_A;
        end
      end
      S_WRITE_A: state_next = (a_q == b_q) ? S_RESULT : S_WRITE_B;
      S_WRITE_B: state_next = S_RESULT;
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Store controls and handshake outputs
  always_comb begin
    in_ready     = (state == S_IDLE);
    st_clear     = 1'b0;
    st_rd_addr   = '0;
    st_wr_en     = 1'b0;
    st_wr_addr   = a_q;
    st_wr_row    = row_a;
    st_wr_label  = label_a;
    st_wr_degree = deg_a;
    case (state)
      S_IDLE: begin
        st_rd_addr = in_item.vertex_a[VW-1:0];
        st_clear   = in_take && (in_item.func == FUNC_CLEAR);
      end
      S_READ_B: st_rd_addr = b_q;
      S_DECIDE: st_rd_addr = '0;
      S_SCAN: begin
        // write back the entry read last cycle if it carries the old label
        st_rd_addr   = scan_idx[VW-1:0];
        st_wr_en     = (st_rd_label == label_b);
        st_wr_addr   = pend_idx;
        st_wr_row    = st_rd_row;
        st_wr_label  = label_a;
        st_wr_degree = st_rd_degree;
      end
      S_WRITE_A: begin
        st_wr_en     = 1'b1;
        st_wr_addr   = a_q;
        st_wr_row    = row_a | (MAX_VERTICES'(1) << b_q);
        st_wr_label  = label_a;
        st_wr_degree = deg_a_new;
      end
      S_WRITE_B: begin
        st_wr_en     = 1'b1;
        st_wr_addr   = b_q;
        st_wr_row    = row_b | (MAX_VERTICES'(1) << a_q);
        st_wr_label  = merge_q ? label_a : label_b;
        st_wr_degree = deg_add(deg_b, 2'd1);
      end
      default: ;
    endcase
  end

  // State register and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cycle_flag  <= 1'b0;
      total_edges <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_take && (in_item.func == FUNC_CLEAR)) begin
        cycle_flag  <= 1'b0;
        total_edges <= '0;
      end
      if (state == S_DECIDE && func_q == FUNC_ADD && new_edge &&
          label_a == st_rd_label) begin
        cycle_flag <= 1'b1;
      end
      if (state == S_WRITE_A && total_edges != EDGE_MAX) begin
        total_edges <= total_edges + EDGE_W'(1);
      end
    end
  end

  // Transaction datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          func_q    <= in_item.func;
          a_q       <= in_item.vertex_a[VW-1:0];
          b_q       <= in_item.vertex_b[VW-1:0];
          present_q <= 1'b0;
          deg_q     <= '0;
          bad_q     <= (in_item.func != FUNC_CLEAR) && in_bad;
          merge_q   <= 1'b0;
        end
      end
      S_READ_B: begin
        row_a   <= st_rd_row;
        label_a <= st_rd_label;
        deg_a   <= st_rd_degree;
      end
      S_DECIDE: begin
        row_b     <= st_rd_row;
        label_b   <= st_rd_label;
        deg_b     <= st_rd_degree;
        present_q <= row_a[b_q];
        deg_q     <= deg_a;
        merge_q   <= (func_q == FUNC_ADD) && new_edge && (label_a != st_rd_label);
        scan_idx  <= (VW+1)'(1);
        pend_idx  <= '0;
      end
      S_SCAN: begin
        if (scan_idx != (VW+1)'(MAX_VERTICES)) begin
          pend_idx <= scan_idx[VW-1:0];
          scan_idx <= scan_idx + (VW+1)'(1);
        end
      end
      S_WRITE_A: deg_q <= deg_a_new;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.edge_present <= present_q;
      out_item.cycle_found  <= cycle_flag;
      out_item.edge_count   <= total_edges;
      out_item.degree_a     <= deg_q;
      out_item.bad_vertex   <= bad_q;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ugct_store.sv
// Per-vertex store: adjacency row, component label and degree in one memory.
`default_nettype none

module ugct_store #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              clear,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  output logic [MAX_VERTICES-1:0]                rd_row,
  output logic [$clog2(MAX_VERTICES)-1:0]        rd_label,
  output logic [ugct_pkg::DEG_W-1:0]             rd_degree,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   wr_addr,
  input  wire logic [MAX_VERTICES-1:0]           wr_row,
  input  wire logic [$clog2(MAX_VERTICES)-1:0]   wr_label,
  input  wire logic [ugct_pkg::DEG_W-1:0]        wr_degree
);
  import ugct_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int W  = MAX_VERTICES + AW + DEG_W;

  logic [W-1:0]            mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid;
  logic [W-1:0]            rd_word;
  logic                    rd_hit;
  logic [AW-1:0]           rd_addr_q;

  // Memory array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_row, wr_label, wr_degree};
    end
    rd_word   <= mem[rd_addr];
    rd_hit    <= valid[rd_addr];
    rd_addr_q <= rd_addr;
  end

  // Entry valid bits; an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Reset value substitution for entries not written since clear
  assign rd_row    = rd_hit ? rd_word[W-1 -: MAX_VERTICES] : '0;
  assign rd_label  = rd_hit ? rd_word[DEG_W +: AW] : rd_addr_q;
  assign rd_degree = rd_hit ? rd_word[DEG_W-1:0] : '0;

endmodule

`default_nettype wire
